// File: hdl/chlp_pkg.sv
package chlp_pkg;

    localparam int MAX_LINE_DEF = 255;

    localparam int TOK_POS_W = 4;
    localparam int HEX_W     = 16;
    localparam int ID_W      = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_TOKEN = 2'd2;

    localparam logic [1:0] TY_DATA = 2'd0;
    localparam logic [1:0] TY_ECHO = 2'd1;
    localparam logic [1:0] TY_ECHO_REPLY = 2'd2;
    localparam logic [1:0] TY_END  = 2'd3;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam int OUT_DATA_W = 64;
    localparam int F_STATUS_LO = 0;
    localparam int F_LEN_LO    = 2;
    localparam int F_ID_LO     = 18;
    localparam int F_TRAIL     = 50;
    localparam int F_TYPE_LO   = 51;
    localparam int F_HB_LO     = 53;
    localparam int F_USED_W    = 62;

    typedef enum logic [2:0] {
        HX_BLANK = 3'd0,
        HX_ZERO  = 3'd1,
        HX_PREFIX = 3'd2,
        HX_DIGITS = 3'd3,
        HX_DONE  = 3'd4
    } t_hex_phase;

    typedef enum logic [2:0] {
        ID_BLANK    = 3'd0,
        ID_POS      = 3'd1,
        ID_NEG      = 3'd2,
        ID_DONE_POS = 3'd3,
        ID_DONE_NEG = 3'd4
    } t_id_phase;

    typedef struct packed {
        logic [TOK_POS_W-1:0] pos;
        logic [1:0]           cnt;
        logic [HEX_W-1:0]     hex_acc;
        t_hex_phase           hex_ph;
        logic [ID_W-1:0]      id_acc;
        logic [ID_W-1:0]      id_val;
        t_id_phase            id_ph;
        logic [3:0]           kw;
        logic [1:0]           sv_type;
        logic                 sv_trail;
    } t_tok;

    typedef struct packed {
        logic [8:0]        header_bytes;
        logic [1:0]        chunk_type;
        logic              trail_flag;
        logic [ID_W-1:0]   chunk_id;
        logic [HEX_W-1:0]  chunk_length;
        logic [1:0]        status;
    } t_result;

    localparam t_tok TOK_CLEAR = '{
        pos: '0, cnt: '0, hex_acc: '0, hex_ph: HX_BLANK, id_acc: '0,
        id_val: '0, id_ph: ID_BLANK, kw: 4'hF, sv_type: TY_DATA, sv_trail: 1'b0
    };

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] kw_id_char(input logic [TOK_POS_W-1:0] p);
        logic [7:0] r;
        unique case (p)
            4'd0:    r = "i";
            4'd1:    r = "d";
            4'd2:    r = "=";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_trail_char(input logic [TOK_POS_W-1:0] p);
        logic [7:0] r;
        unique case (p)
            4'd0:    r = "t";
            4'd1:    r = "r";
            4'd2:    r = "a";
            4'd3:    r = "i";
            4'd4:    r = "l";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_echo_char(input logic [TOK_POS_W-1:0] p);
        logic [7:0] r;
        unique case (p)
            4'd0:    r = "e";
            4'd1:    r = "c";
            4'd2:    r = "h";
            4'd3:    r = "o";
            4'd4:    r = "-";
            4'd5:    r = "r";
            4'd6:    r = "e";
            4'd7:    r = "s";
            4'd8:    r = "p";
            4'd9:    r = "o";
            4'd10:   r = "n";
            4'd11:   r = "s";
            4'd12:   r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/chunk_header_line_parser.sv
// A result is registered at the edge accepting the LF closing its line, or the byte that
// pushes the line past the length limit (into the skid register while r_out is full).
// Throughput: one byte per cycle while the skid register is empty; bytes keep
// flowing while a result waits, held in an output and a skid register (two results deep).
// Reset (i_rst_n low, synchronous): clears the line parser and empties the result buffer.
module chunk_header_line_parser #(
    parameter int MAX_LINE = chlp_pkg::MAX_LINE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // byte_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, chunk_length, chunk_id, trail_flag, chunk_type, header_bytes, zero pad
    output logic [chlp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int LC_W = $clog2(MAX_LINE + 2);

    logic             r_discard, n_discard;
    logic             r_pend, n_pend;
    logic [LC_W-1:0]  r_lc, n_lc;
    chlp_pkg::t_tok   r_tok, n_tok;

    chlp_pkg::t_result r_out, r_skid, res;
    logic              r_out_v, r_skid_v, res_v;

    logic              in_acc, take;
    chlp_pkg::t_tok    tok_cr, tok_fin;
    logic [LC_W-1:0]   lc_inc, lc_inc2;
    logic [LC_W:0]     hb_sum;

    function automatic chlp_pkg::t_tok tok_finish(input chlp_pkg::t_tok s);
        chlp_pkg::t_tok t;
        logic           neg;
        t = s;
        neg = (s.id_ph == chlp_pkg::ID_NEG) || (s.id_ph == chlp_pkg::ID_DONE_NEG);
        if (s.cnt == 2'd2) begin
            if (s.kw[0] && s.pos >= 4'd3) begin
                if (neg) begin
                    t.id_acc = '0 - s.id_val;
                end else begin
                    t.id_acc = s.id_val[chlp_pkg::ID_W-1] ? 32'h7FFF_FFFF : s.id_val;
                end
            end
            if (s.kw[1] && s.pos == 4'd5) t.sv_trail = 1'b1;
            if (s.kw[2] && s.pos == 4'd4) t.sv_type = chlp_pkg::TY_ECHO;
            if (s.kw[3] && s.pos == 4'd13) t.sv_type = chlp_pkg::TY_ECHO_REPLY;
        end
        return t;
    endfunction

    function automatic chlp_pkg::t_tok tok_step(input chlp_pkg::t_tok s, input logic [7:0] c);
        chlp_pkg::t_tok t;
        logic           hx_isd, id_isd, bl;
        logic [3:0]     hx_d;
        logic [20:0]    hx_v;
        logic [35:0]    id_v;
        t = s;
        bl = chlp_pkg::is_blank(c);
        hx_isd = 1'b1;
        hx_d = 4'd0;
        if (c >= "0" && c <= "9") hx_d = 4'(c - "0");
        else if (c >= "a" && c <= "f") hx_d = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") hx_d = 4'(c - "A" + 8'd10);
        else hx_isd = 1'b0;
        id_isd = (c >= "0" && c <= "9");
        hx_v = {s.hex_acc, 4'd0} + 21'(hx_d);
        id_v = 36'({4'd0, s.id_val} * 36'd10) + 36'(c[3:0]);
        if (c == chlp_pkg::CH_SEMI) begin
            if (s.pos != '0) t = tok_finish(s);
            t.pos = '0;
        end else begin
            if (s.pos == '0) begin
                t.cnt = (s.cnt < 2'd2) ? s.cnt + 2'd1 : 2'd2;
                t.kw = 4'hF;
                t.id_ph = chlp_pkg::ID_BLANK;
                t.id_val = '0;
            end
            if (t.cnt == 2'd1) begin
                unique case (s.hex_ph)
                    chlp_pkg::HX_BLANK: begin
                        if (!bl) begin
                            if (c == "0") t.hex_ph = chlp_pkg::HX_ZERO;
                            else if (hx_isd) begin
                                t.hex_acc = (hx_v > 21'd65535) ? 16'hFFFF : hx_v[15:0];
                                t.hex_ph = chlp_pkg::HX_DIGITS;
                            end else t.hex_ph = chlp_pkg::HX_DONE;
                        end
                    end
                    chlp_pkg::HX_ZERO: begin
                        if (c == "x" || c == "X") t.hex_ph = chlp_pkg::HX_PREFIX;
                        else if (hx_isd) begin
                            t.hex_acc = (hx_v > 21'd65535) ? 16'hFFFF : hx_v[15:0];
                            t.hex_ph = chlp_pkg::HX_DIGITS;
                        end else t.hex_ph = chlp_pkg::HX_DONE;
                    end
                    chlp_pkg::HX_PREFIX, chlp_pkg::HX_DIGITS: begin
                        if (hx_isd) begin
                            t.hex_acc = (hx_v > 21'd65535) ? 16'hFFFF : hx_v[15:0];
                            t.hex_ph = chlp_pkg::HX_DIGITS;
                        end else t.hex_ph = chlp_pkg::HX_DONE;
                    end
                    default: ;
                endcase
            end else begin
                if (s.pos < 4'd3 && chlp_pkg::kw_id_char(s.pos) != c) t.kw[0] = 1'b0;
                if (!(s.pos < 4'd5 && chlp_pkg::kw_trail_char(s.pos) == c)) t.kw[1] = 1'b0;
                if (!(s.pos < 4'd4 && chlp_pkg::kw_echo_char(s.pos) == c)) t.kw[2] = 1'b0;
                if (!(s.pos < 4'd13 && chlp_pkg::kw_echo_char(s.pos) == c)) t.kw[3] = 1'b0;
                if (t.kw[0] && s.pos >= 4'd3) begin
                    if (t.id_ph == chlp_pkg::ID_BLANK) begin
                        if (!bl) begin
                            if (c == "+") t.id_ph = chlp_pkg::ID_POS;
                            else if (c == "-") t.id_ph = chlp_pkg::ID_NEG;
                            else if (id_isd) begin
                                t.id_ph = chlp_pkg::ID_POS;
                                t.id_val = 32'(c[3:0]);
                            end else t.id_ph = chlp_pkg::ID_DONE_POS;
                        end
                    end else if (t.id_ph == chlp_pkg::ID_POS) begin
                        if (id_isd) t.id_val = (id_v > 36'h8000_0000) ? 32'h8000_0000 : id_v[31:0];
                        else t.id_ph = chlp_pkg::ID_DONE_POS;
                    end else if (t.id_ph == chlp_pkg::ID_NEG) begin
                        if (id_isd) t.id_val = (id_v > 36'h8000_0000) ? 32'h8000_0000 : id_v[31:0];
                        else t.id_ph = chlp_pkg::ID_DONE_NEG;
                    end
                end
            end
            if (s.pos != '1) t.pos = s.pos + 4'd1;
        end
        return t;
    endfunction

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign take   = r_out_v && m_axis_tready;

    assign lc_inc  = r_lc + LC_W'(1);
    assign tok_cr  = tok_step(r_tok, chlp_pkg::CH_CR);
    assign tok_fin = (r_tok.pos != '0) ? tok_finish(r_tok) : r_tok;
    assign hb_sum  = {1'b0, r_lc} + (LC_W+1)'(2);
    assign lc_inc2 = r_lc + LC_W'(2);

    always_comb begin
        n_discard = r_discard;
        n_pend    = r_pend;
        n_lc      = r_lc;
        n_tok     = r_tok;
        res_v     = 1'b0;
        res       = '0;
        if (r_discard) begin
            if (r_pend && s_axis_tdata == chlp_pkg::CH_LF) begin
                n_discard = 1'b0;
                n_pend    = 1'b0;
                n_lc      = '0;
                n_tok     = chlp_pkg::TOK_CLEAR;
            end else begin
                n_pend = (s_axis_tdata == chlp_pkg::CH_CR);
            end
        end else if (r_pend && s_axis_tdata == chlp_pkg::CH_LF) begin
            res_v = 1'b1;
            if (tok_fin.cnt == 2'd0) begin
                res.status = chlp_pkg::ST_NO_TOKEN;
            end else begin
                res.status       = chlp_pkg::ST_OK;
                res.chunk_length = tok_fin.hex_acc;
                res.chunk_id     = tok_fin.id_acc;
                res.trail_flag   = tok_fin.sv_trail;
                res.chunk_type   = (tok_fin.hex_acc == '0) ? chlp_pkg::TY_END : tok_fin.sv_type;
                res.header_bytes = 9'(hb_sum);
            end
            n_pend = 1'b0;
            n_lc   = '0;
            n_tok  = chlp_pkg::TOK_CLEAR;
        end else if (r_pend && lc_inc > LC_W'(MAX_LINE)) begin
            res_v      = 1'b1;
            res.status = chlp_pkg::ST_TOO_LONG;
            n_discard  = 1'b1;
            n_lc       = lc_inc;
            n_pend     = (s_axis_tdata == chlp_pkg::CH_CR);
        end else if (r_pend) begin
            if (s_axis_tdata == chlp_pkg::CH_CR) begin
                n_pend = 1'b1;
                n_lc   = lc_inc;
                n_tok  = tok_cr;
            end else if (lc_inc2 > LC_W'(MAX_LINE)) begin
                res_v      = 1'b1;
                res.status = chlp_pkg::ST_TOO_LONG;
                n_discard  = 1'b1;
                n_pend     = 1'b0;
                n_lc       = lc_inc2;
                n_tok      = tok_cr;
            end else begin
                n_pend = 1'b0;
                n_lc   = lc_inc2;
                n_tok  = tok_step(tok_cr, s_axis_tdata);
            end
        end else if (s_axis_tdata == chlp_pkg::CH_CR) begin
            n_pend = 1'b1;
        end else if (lc_inc > LC_W'(MAX_LINE)) begin
            res_v      = 1'b1;
            res.status = chlp_pkg::ST_TOO_LONG;
            n_discard  = 1'b1;
            n_lc       = lc_inc;
        end else begin
            n_lc  = lc_inc;
            n_tok = tok_step(r_tok, s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard <= 1'b0;
            r_pend    <= 1'b0;
            r_lc      <= '0;
            r_tok     <= chlp_pkg::TOK_CLEAR;
        end else if (in_acc) begin
            r_discard <= n_discard;
            r_pend    <= n_pend;
            r_lc      <= n_lc;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out   <= res;
                r_out_v <= in_acc && res_v;
            end
        end else if (!r_out_v) begin
            r_out   <= res;
            r_out_v <= in_acc && res_v;
        end else if (in_acc && res_v) begin
            r_skid   <= res;
            r_skid_v <= 1'b1;
        end
    end

    assign s_axis_tready = !r_skid_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = chlp_pkg::OUT_DATA_W'(r_out);

endmodule

// File: hdl/chlp_checker.sv
module chlp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [chlp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0]  st;
    logic [8:0]  hb;
    logic [15:0] len;
    logic [1:0]  ty;

    assign st  = m_axis_tdata[chlp_pkg::F_STATUS_LO +: 2];
    assign hb  = m_axis_tdata[chlp_pkg::F_HB_LO +: 9];
    assign len = m_axis_tdata[chlp_pkg::F_LEN_LO +: 16];
    assign ty  = m_axis_tdata[chlp_pkg::F_TYPE_LO +: 2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != chlp_pkg::ST_OK
        |-> m_axis_tdata[chlp_pkg::OUT_DATA_W-1:chlp_pkg::F_LEN_LO] == '0
            && (st == chlp_pkg::ST_TOO_LONG || st == chlp_pkg::ST_NO_TOKEN))
        else $error("error result carries stray fields");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st == chlp_pkg::ST_OK
        |-> hb >= 9'd2 && (len != '0 || ty == chlp_pkg::TY_END))
        else $error("ok result inconsistent");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("buffer not empty after reset");

endmodule

bind chunk_header_line_parser chlp_checker u_chlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [103:0] KW_ID_TXT    = "id=";
    localparam logic [103:0] KW_TRAIL_TXT = "trail";
    localparam logic [103:0] KW_ECHO_TXT  = "echo";
    localparam logic [103:0] KW_REPLY_TXT = "echo-response";
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // byte_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, chunk_length, chunk_id, trail_flag, chunk_type, header_bytes, zero pad
    logic [chlp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int faults = 0;
    int quiet_cycles = 0;

    chlp_pkg::t_result    results_due[$];
    chlp_pkg::t_result    seen;
    chlp_pkg::t_result    due;
    logic [7:0]           line_buf[$];

    int                   line_len;
    bit                   cr_held;
    bit                   skipping = 1'b0;
    int                   tok_pos;
    int                   tok_cnt;
    logic [15:0]          len_acc;
    chlp_pkg::t_hex_phase len_ph;
    logic [31:0]          id_acc;
    logic [32:0]          id_mag;
    chlp_pkg::t_id_phase  id_ph;
    logic [3:0]           kw_live;
    logic [1:0]           ty_seen;
    logic                 trail_seen;

    chunk_header_line_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_line_state();
        line_len = 0;
        cr_held = 1'b0;
        tok_pos = 0;
        tok_cnt = 0;
        len_acc = '0;
        len_ph = chlp_pkg::HX_BLANK;
        id_acc = '0;
        id_mag = '0;
        id_ph = chlp_pkg::ID_BLANK;
        kw_live = 4'hF;
        ty_seen = chlp_pkg::TY_DATA;
        trail_seen = 1'b0;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic hex_value(input logic [7:0] c, output logic [3:0] d);
        d = '0;
        if (c >= "0" && c <= "9") begin
            d = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            d = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            d = 4'(c - "A" + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic kw_at(input logic [103:0] word, input int n, input int p,
                                   input logic [7:0] c);
        if (p >= n) return 1'b0;
        return word[8*(n-1-p) +: 8] == c;
    endfunction

    function automatic void take_len_digit(input logic [3:0] d);
        logic [31:0] v;
        v = 32'(len_acc) * 16 + 32'(d);
        len_acc = (v > 32'd65535) ? 16'hFFFF : v[15:0];
        len_ph = chlp_pkg::HX_DIGITS;
    endfunction

    function automatic void len_step(input logic [7:0] c);
        logic [3:0] d;
        logic       isd;
        isd = hex_value(c, d);
        case (len_ph)
            chlp_pkg::HX_BLANK: begin
                if (!is_space(c)) begin
                    if (c == "0") len_ph = chlp_pkg::HX_ZERO;
                    else if (isd) take_len_digit(d);
                    else len_ph = chlp_pkg::HX_DONE;
                end
            end
            chlp_pkg::HX_ZERO: begin
                if (c == "x" || c == "X") len_ph = chlp_pkg::HX_PREFIX;
                else if (isd) take_len_digit(d);
                else len_ph = chlp_pkg::HX_DONE;
            end
            chlp_pkg::HX_PREFIX, chlp_pkg::HX_DIGITS: begin
                if (isd) take_len_digit(d);
                else len_ph = chlp_pkg::HX_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void id_step(input logic [7:0] c);
        logic [63:0] v;
        logic        isd;
        isd = c >= "0" && c <= "9";
        case (id_ph)
            chlp_pkg::ID_BLANK: begin
                if (!is_space(c)) begin
                    if (c == "+") begin
                        id_ph = chlp_pkg::ID_POS;
                    end else if (c == "-") begin
                        id_ph = chlp_pkg::ID_NEG;
                    end else if (isd) begin
                        id_ph = chlp_pkg::ID_POS;
                        id_mag = 33'(c - "0");
                    end else begin
                        id_ph = chlp_pkg::ID_DONE_POS;
                    end
                end
            end
            chlp_pkg::ID_POS, chlp_pkg::ID_NEG: begin
                if (isd) begin
                    v = 64'(id_mag) * 10 + 64'(c - "0");
                    id_mag = (v > 64'd2147483648) ? 33'd2147483648 : v[32:0];
                end else begin
                    id_ph = (id_ph == chlp_pkg::ID_POS) ? chlp_pkg::ID_DONE_POS
                                                        : chlp_pkg::ID_DONE_NEG;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void close_token();
        logic [31:0] m;
        logic        neg;
        if (tok_cnt < 2) return;
        if (kw_live[0] && tok_pos >= 3) begin
            neg = id_ph == chlp_pkg::ID_NEG || id_ph == chlp_pkg::ID_DONE_NEG;
            m = id_mag[31:0];
            if (neg) id_acc = 32'd0 - m;
            else id_acc = (id_mag > 33'd2147483647) ? 32'h7FFF_FFFF : m;
        end
        if (kw_live[1] && tok_pos == 5) trail_seen = 1'b1;
        if (kw_live[2] && tok_pos == 4) ty_seen = chlp_pkg::TY_ECHO;
        if (kw_live[3] && tok_pos == 13) ty_seen = chlp_pkg::TY_ECHO_REPLY;
    endfunction

    function automatic void token_step(input logic [7:0] c);
        int p;
        if (c == chlp_pkg::CH_SEMI) begin
            if (tok_pos > 0) close_token();
            tok_pos = 0;
            return;
        end
        if (tok_pos == 0) begin
            if (tok_cnt < 2) tok_cnt++;
            kw_live = 4'hF;
            id_ph = chlp_pkg::ID_BLANK;
            id_mag = '0;
        end
        p = tok_pos;
        if (tok_cnt == 1) begin
            len_step(c);
        end else begin
            if (p < 3 && !kw_at(KW_ID_TXT, 3, p, c)) kw_live[0] = 1'b0;
            if (!kw_at(KW_TRAIL_TXT, 5, p, c)) kw_live[1] = 1'b0;
            if (!kw_at(KW_ECHO_TXT, 4, p, c)) kw_live[2] = 1'b0;
            if (!kw_at(KW_REPLY_TXT, 13, p, c)) kw_live[3] = 1'b0;
            if (kw_live[0] && p >= 3) id_step(c);
        end
        tok_pos++;
    endfunction

    function automatic logic line_step(input logic [7:0] c);
        line_len++;
        if (line_len > chlp_pkg::MAX_LINE_DEF) begin
            skipping = 1'b1;
            return 1'b1;
        end
        token_step(c);
        return 1'b0;
    endfunction

    function automatic void track_header_byte(input logic [7:0] c);
        chlp_pkg::t_result r;
        r = '0;
        if (skipping) begin
            if (cr_held && c == chlp_pkg::CH_LF) begin
                clear_line_state();
                skipping = 1'b0;
            end else begin
                cr_held = c == chlp_pkg::CH_CR;
            end
            return;
        end
        if (cr_held) begin
            cr_held = 1'b0;
            if (c == chlp_pkg::CH_LF) begin
                if (tok_pos > 0) close_token();
                if (tok_cnt == 0) begin
                    r.status = chlp_pkg::ST_NO_TOKEN;
                end else begin
                    r.status = chlp_pkg::ST_OK;
                    r.chunk_length = len_acc;
                    r.chunk_id = id_acc;
                    r.trail_flag = trail_seen;
                    r.chunk_type = (len_acc == 0) ? chlp_pkg::TY_END : ty_seen;
                    r.header_bytes = 9'(line_len + 2);
                end
                results_due.push_back(r);
                clear_line_state();
                return;
            end
            if (line_step(chlp_pkg::CH_CR)) begin
                r.status = chlp_pkg::ST_TOO_LONG;
                results_due.push_back(r);
                cr_held = c == chlp_pkg::CH_CR;
                return;
            end
        end
        if (c == chlp_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        if (line_step(c)) begin
            r.status = chlp_pkg::ST_TOO_LONG;
            results_due.push_back(r);
        end
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[chlp_pkg::F_USED_W-1:0];
            if (results_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result at %0t: status %0d", $time, seen.status);
            end else begin
                due = results_due.pop_front();
                if (seen.status !== due.status || seen.chunk_length !== due.chunk_length ||
                    seen.chunk_id !== due.chunk_id || seen.trail_flag !== due.trail_flag ||
                    seen.chunk_type !== due.chunk_type ||
                    seen.header_bytes !== due.header_bytes) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("mismatch at %0t", $time);
                        $display("  expected st %0d len %h id %0d tr %0d ty %0d hb %0d",
                                 due.status, due.chunk_length, $signed(due.chunk_id),
                                 due.trail_flag, due.chunk_type, due.header_bytes);
                        $display("  actual   st %0d len %h id %0d tr %0d ty %0d hb %0d",
                                 seen.status, seen.chunk_length, $signed(seen.chunk_id),
                                 seen.trail_flag, seen.chunk_type, seen.header_bytes);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_header_byte(b);
        bytes_sent++;
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        pause_sender();
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i]) push_byte(line_buf[i]);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void add_hex(input int n);
        repeat (n) line_buf.push_back(HEX_CHARS[$urandom_range(0, 21)]);
    endfunction

    function automatic void add_dec(input int n);
        repeat (n) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0:       return chlp_pkg::CH_CR;
            1:       return chlp_pkg::CH_LF;
            2:       return chlp_pkg::CH_SEMI;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic string kw_word(input int k);
        case (k)
            0:       return "id=";
            1:       return "trail";
            2:       return "echo";
            default: return "echo-response";
        endcase
    endfunction

    function automatic void add_token();
        string s;
        int    n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                add_text("id=");
                if ($urandom_range(0, 3) == 0) line_buf.push_back(" ");
                case ($urandom_range(0, 3))
                    0:       line_buf.push_back("-");
                    1:       line_buf.push_back("+");
                    default: ;
                endcase
                add_dec(($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                    : $urandom_range(0, 9));
                if ($urandom_range(0, 7) == 0) line_buf.push_back(pick_printable());
            end
            3: add_text("trail");
            4: add_text("echo");
            5: add_text("echo-response");
            6, 7: begin
                s = kw_word($urandom_range(0, 3));
                n = $urandom_range(0, s.len());
                for (int i = 0; i < n; i++) line_buf.push_back(s[i]);
                line_buf.push_back(pick_printable());
            end
            default: repeat ($urandom_range(1, 6)) line_buf.push_back(pick_printable());
        endcase
    endfunction

    function automatic void build_random_line();
        int kind;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 20)) line_buf.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(0, 2))
                line_buf.push_back(($urandom_range(0, 3) == 0) ? 8'h09 : 8'h20);
            case ($urandom_range(0, 9))
                0, 1:    add_text("0x");
                2:       add_text("0X");
                3:       add_text("0");
                4:       line_buf.push_back($urandom_range(0, 1) ? "+" : "-");
                default: ;
            endcase
            add_hex(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0) line_buf.push_back(pick_printable());
            if ($urandom_range(0, 9) == 0) begin
                line_buf.push_back(chlp_pkg::CH_CR);
                line_buf.push_back(8'($urandom_range(32, 126)));
            end
            repeat ($urandom_range(0, 4)) begin
                line_buf.push_back(chlp_pkg::CH_SEMI);
                if ($urandom_range(0, 7) == 0) line_buf.push_back(chlp_pkg::CH_SEMI);
                add_token();
            end
            if ($urandom_range(0, 5) == 0) line_buf.push_back(chlp_pkg::CH_SEMI);
        end
        line_buf.push_back(chlp_pkg::CH_CR);
        line_buf.push_back(chlp_pkg::CH_LF);
    endfunction

    function automatic void fill_line(input string head, input int total);
        line_buf.delete();
        add_text(head);
        while (line_buf.size() < total) line_buf.push_back("z");
    endfunction

    task automatic test_basic_lines();
        send_text("1a\r\n");
        send_text("0x10;id=42;trail;echo\r\n");
        send_text("FFFFF;id=-99999999999;echo-response\r\n");
        send_text("0;echo;trail\r\n");
        send_text(" \t0X7f ;id= +12;id=7;echo;echo-response\r\n");
        send_text("a;id=2147483647;id=+2147483648\r\n");
        send_text("b;id=-2147483648\r\n");
    endtask

    task automatic test_special_cases();
        push_byte(8'h0B);
        push_byte(8'h0C);
        push_byte(chlp_pkg::CH_LF);
        send_text("9\r\n");
        send_text(";;\r\n");
        send_text("\r\n");
        send_text("-5;id=\r\n");
        send_text("5;ech;trails;echo-responsex;id;xid=3\r\n");
        send_text("3\rx;id=1\r\n");
        send_text("c;\r\r\n");
        send_text("d;");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        send_text("\r\n");
        send_text("0x;id=5x\r\n");
        send_text(";;e;;id=3;;\r\n");
        send_text("0001;id=--5\r\n");
        send_text("id=4\r\n");
    endtask

    task automatic test_long_lines();
        fill_line("10;trail;", chlp_pkg::MAX_LINE_DEF);
        add_text("\r\n");
        send_line_buf();
        fill_line("2;", chlp_pkg::MAX_LINE_DEF);
        add_text("\r\r\rq\r\n");
        send_line_buf();
        send_text("4;echo\r\n");
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int nbytes);
        int start;
        idle_pct = idle;
        stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) begin
            build_random_line();
            send_line_buf();
        end
    endtask

    initial begin
        clear_line_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_lines();
        test_special_cases();
        test_long_lines();
        test_random_traffic(0, 0, 60);
        wait_drained();
        test_random_traffic(49, 0, 60);
        test_random_traffic(0, 49, 60);
        wait_drained();
        test_random_traffic(21, 21, 60);

        pause_sender();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
